### sv/gdbd_pkg.sv
// Package for the Gregorian date difference core.
// Holds the controller states, the command and status structs, and the calendar tables.
// No dependencies.
package gdbd_pkg;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_S,
        ST_NUM_S,
        ST_DIV_E,
        ST_NUM_E,
        ST_DONE
    } gdbd_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture the input transaction
        logic div;      // form the quotients by 100 of the selected year
        logic num;      // form the day number of the selected date
        logic sel_end;  // 0 selects the start date, 1 the end date
        logic finish;   // form the result and load the output register
    } gdbd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_busy; // output register holds a result that is not taken this cycle
    } gdbd_status_t;

    localparam int unsigned NUM_W     = 23;
    localparam int unsigned COUNT_W   = 22;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 22'd4194303;

    // floor(x / 100) = (x * RECIP100) >> RECIP_SHIFT for every 14-bit x.
    localparam logic [12:0] RECIP100    = 13'd5243;
    localparam int unsigned RECIP_SHIFT = 19;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    // Length of a month in a common year; meaningless codes give zero.
    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // Days in the months before month m of a common year.
    function automatic logic [8:0] days_before(input logic [3:0] m);
        logic [8:0] days;
        unique case (m)
            4'd1:    days = 9'd0;
            4'd2:    days = 9'd31;
            4'd3:    days = 9'd59;
            4'd4:    days = 9'd90;
            4'd5:    days = 9'd120;
            4'd6:    days = 9'd151;
            4'd7:    days = 9'd181;
            4'd8:    days = 9'd212;
            4'd9:    days = 9'd243;
            4'd10:   days = 9'd273;
            4'd11:   days = 9'd304;
            4'd12:   days = 9'd334;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

endpackage

### sv/gdbd_ctrl.sv
// Controller of the Gregorian date difference core.
// Sequences the datapath through both dates and the final difference.
// Depends on gdbd_pkg.
module gdbd_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  gdbd_pkg::gdbd_status_t status,
    output gdbd_pkg::gdbd_cmd_t    cmd
);
    import gdbd_pkg::*;

    gdbd_state_t state_reg;
    gdbd_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        s_tready    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV_S;
                end
            end
            ST_DIV_S:
            begin
                cmd.div    = 1'b1;
                state_next = ST_NUM_S;
            end
            ST_NUM_S:
            begin
                cmd.num    = 1'b1;
                state_next = ST_DIV_E;
            end
            ST_DIV_E:
            begin
                cmd.div     = 1'b1;
                cmd.sel_end = 1'b1;
                state_next  = ST_NUM_E;
            end
            ST_NUM_E:
            begin
                cmd.num     = 1'b1;
                cmd.sel_end = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE:
            begin
                if (!status.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // An accepted transaction always starts the start-date division.
    a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && s_tvalid) |=> (state_reg == ST_DIV_S))
        else $error("accepted transaction did not start the sequence");

    // Each day number follows the division of the same date.
    a_num_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.num |-> ($past(cmd.div) && $past(cmd.sel_end) == cmd.sel_end))
        else $error("day number formed without its division");

    // The result is only formed once both dates are done.
    a_finish_order: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && $past(state_reg) == ST_NUM_E) |-> $past(cmd.num))
        else $error("finish issued out of order");
`endif

endmodule

### sv/gdbd_dp.sv
// Datapath of the Gregorian date difference core.
// Holds the input dates, the day-number arithmetic and the output register.
// Depends on gdbd_pkg.
module gdbd_dp (
    input  logic                   clk,
    input  logic                   rst_n,
    input  gdbd_pkg::gdbd_cmd_t    cmd,
    output gdbd_pkg::gdbd_status_t status,
    input  logic [4:0]             start_day,
    input  logic [3:0]             start_month,
    input  logic [13:0]            start_year,
    input  logic [4:0]             end_day,
    input  logic [3:0]             end_month,
    input  logic [13:0]            end_year,
    input  logic                   include_end,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [21:0]            day_count,
    output logic                   bad_date
);
    import gdbd_pkg::*;

    // Captured transaction.
    logic [4:0]  sd_reg, ed_reg;
    logic [3:0]  sm_reg, em_reg;
    logic [13:0] sy_reg, ey_reg;
    logic        inc_reg;

    // Working registers.
    logic [7:0]         q_reg;      // year / 100
    logic [7:0]         qp_reg;     // (year - 1) / 100
    logic [NUM_W-1:0]   num_a_reg;
    logic [NUM_W-1:0]   num_b_reg;
    logic               bad_reg;

    // Output register.
    logic               out_valid_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               bad_out_reg;

    // Selected date.
    logic [4:0]  d_cur;
    logic [3:0]  m_cur;
    logic [13:0] y_cur;
    logic [13:0] p_cur;

    assign d_cur = cmd.sel_end ? ed_reg : sd_reg;
    assign m_cur = cmd.sel_end ? em_reg : sm_reg;
    assign y_cur = cmd.sel_end ? ey_reg : sy_reg;
    assign p_cur = y_cur - 14'd1;

    // Division by 100 through the reciprocal.
    logic [26:0] qy_prod;
    logic [26:0] qp_prod;

    assign qy_prod = 27'(y_cur) * 27'(RECIP100);
    assign qp_prod = 27'(p_cur) * 27'(RECIP100);

    // Leap year test and day number of the selected date.
    logic             div100;
    logic             leap;
    logic [4:0]       len_cur;
    logic             valid_cur;
    logic [NUM_W-1:0] leaps_cnt;
    logic [NUM_W-1:0] year_days;
    logic [NUM_W-1:0] num_cur;

    always_comb
    begin
        div100    = ((14'(q_reg) * 14'd100) == y_cur);
        leap      = ((y_cur[1:0] == 2'd0) && !div100) || (div100 && (q_reg[1:0] == 2'd0));
        len_cur   = (m_cur == MONTH_FEB) ? (leap ? 5'd29 : 5'd28) : month_len(m_cur);
        valid_cur = (m_cur >= MONTH_JAN) && (m_cur <= MONTH_DEC)
                    && (d_cur != 5'd0) && (d_cur <= len_cur);
        if (y_cur == 14'd0)
        begin
            leaps_cnt = '0;
        end
        else
        begin
            leaps_cnt = NUM_W'(p_cur[13:2]) - NUM_W'(qp_reg) + NUM_W'(qp_reg[7:2])
                        + NUM_W'(1);
        end
        year_days = NUM_W'(y_cur) * NUM_W'(365);
        num_cur   = year_days + leaps_cnt + NUM_W'(days_before(m_cur))
                    + NUM_W'((m_cur > MONTH_FEB) && leap) + NUM_W'(d_cur);
    end

    // Difference, include-end and saturation.
    logic [NUM_W-1:0]   diff;
    logic [NUM_W:0]     sum;
    logic [COUNT_W-1:0] count_fin;

    always_comb
    begin
        diff = (num_a_reg < num_b_reg) ? (num_b_reg - num_a_reg) : '0;
        sum  = (NUM_W+1)'(diff) + (NUM_W+1)'(inc_reg);
        if (bad_reg)
        begin
            count_fin = '0;
        end
        else if (sum > (NUM_W+1)'(COUNT_MAX))
        begin
            count_fin = COUNT_MAX;
        end
        else
        begin
            count_fin = sum[COUNT_W-1:0];
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sd_reg  <= start_day;
            sm_reg  <= start_month;
            sy_reg  <= start_year;
            ed_reg  <= end_day;
            em_reg  <= end_month;
            ey_reg  <= end_year;
            inc_reg <= include_end;
            bad_reg <= 1'b0;
        end
        if (cmd.div)
        begin
            q_reg  <= qy_prod[RECIP_SHIFT +: 8];
            qp_reg <= qp_prod[RECIP_SHIFT +: 8];
        end
        if (cmd.num)
        begin
            if (cmd.sel_end)
            begin
                num_b_reg <= num_cur;
            end
            else
            begin
                num_a_reg <= num_cur;
            end
            if (!valid_cur)
            begin
                bad_reg <= 1'b1;
            end
        end
        if (cmd.finish)
        begin
            count_reg   <= count_fin;
            bad_out_reg <= bad_reg;
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.out_busy = out_valid_reg && !out_ready;
    assign out_valid       = out_valid_reg;
    assign day_count       = count_reg;
    assign bad_date        = bad_out_reg;

`ifndef SYNTHESIS
    // A flagged date always carries a zero count.
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && bad_date) |-> (day_count == '0))
        else $error("bad date with nonzero count");

    // A result is never formed over one that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !status.out_busy)
        else $error("output register overwritten");

    // Forming a result always presents it in the next cycle.
    a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid)
        else $error("result not presented after finish");
`endif

endmodule

### sv/gregorian_days_between_dates_core.sv
// Top level of the Gregorian date difference core.
// Joins the controller gdbd_ctrl and the datapath gdbd_dp.
// Depends on gdbd_pkg, gdbd_ctrl and gdbd_dp.
//
//   Channel   Direction  Contents
//   s_*       in         two dates and the include-end flag
//   m_*       out        day count and the bad-date flag
//
// A transaction passes from acceptance to the result register in steps: one to
// capture, two per date (quotient by 100, then day number), one to subtract.
// The next transaction is taken in the cycle after the result is formed, so a
// new one cannot enter before the previous one has gone through every step.
// A stalled output holds the sequence at its final step until the result is taken.
// Reset clears the controller and the output valid flag.
module gregorian_days_between_dates_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // start_day, start_month, start_year, end_day, end_month, end_year, zero fill
    input  logic [47:0] s_tdata,
    // include_end
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // day_count, zero fill
    output logic [23:0] m_tdata,
    // bad_date
    output logic [0:0]  m_tuser
);
    import gdbd_pkg::*;

    gdbd_cmd_t    cmd;
    gdbd_status_t status;
    logic [21:0]  day_count;
    logic         bad_date;

    gdbd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    gdbd_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .start_day   (s_tdata[4:0]),
        .start_month (s_tdata[8:5]),
        .start_year  (s_tdata[22:9]),
        .end_day     (s_tdata[27:23]),
        .end_month   (s_tdata[31:28]),
        .end_year    (s_tdata[45:32]),
        .include_end (s_tuser[0]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .day_count   (day_count),
        .bad_date    (bad_date)
    );

    // Result packing.
    assign m_tdata = {2'b00, day_count};
    assign m_tuser = bad_date;

endmodule

### verif/tb_top.sv
// Self-checking testbench for the Gregorian date difference core.
// Drives date pairs over the stream input, predicts the day count and bad-date flag,
// and compares each result transaction. Depends on gdbd_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 200;
    localparam int HOLD_AT_RESULT = 30;
    localparam int RANDOM_ITEMS   = 75;
    localparam int DRAIN_CYCLES   = 20;
    localparam int SHOWN_ERRORS   = 10;

    // Row kinds of the directed table.
    localparam logic BY_MODEL = 1'b0;
    localparam logic TYPED    = 1'b1;

    // Month lengths of a common year and days before each month.
    localparam int LEN_TABLE [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    localparam int CUM_TABLE [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

    typedef struct packed {
        logic [4:0]  sd;
        logic [3:0]  sm;
        logic [13:0] sy;
        logic [4:0]  ed;
        logic [3:0]  em;
        logic [13:0] ey;
        logic        inc;
    } date_query_t;

    typedef struct packed {
        logic [gdbd_pkg::COUNT_W-1:0] count;
        logic                         bad;
    } day_result_t;

    typedef struct packed {
        date_query_t q;
        logic        kind;
        day_result_t res;
    } stim_row_t;

    localparam day_result_t NO_RES  = '{22'd0, 1'b0};
    localparam day_result_t BAD_RES = '{22'd0, 1'b1};
    localparam day_result_t SAT_RES = '{gdbd_pkg::COUNT_MAX, 1'b0};

    // Directed stimulus: extremes, bad dates, ordering and saturation.
    localparam int DIRECTED_ROWS = 25;
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{'{5'd1, 4'd1, 14'd1, 5'd1, 4'd1, 14'd1, 1'b0}, TYPED, NO_RES},
        '{'{5'd1, 4'd1, 14'd1, 5'd1, 4'd1, 14'd1, 1'b1}, TYPED, '{22'd1, 1'b0}},
        '{'{5'd1, 4'd1, 14'd1, 5'd31, 4'd12, 14'd9999, 1'b0}, BY_MODEL, NO_RES},
        '{'{5'd1, 4'd1, 14'd1, 5'd31, 4'd12, 14'd9999, 1'b1}, BY_MODEL, NO_RES},
        '{'{5'd1, 4'd1, 14'd0, 5'd31, 4'd12, 14'd16383, 1'b0}, TYPED, SAT_RES},
        '{'{5'd1, 4'd1, 14'd0, 5'd31, 4'd12, 14'd16383, 1'b1}, TYPED, SAT_RES},
        '{'{5'd31, 4'd12, 14'd9999, 5'd1, 4'd1, 14'd1, 1'b0}, TYPED, NO_RES},
        '{'{5'd31, 4'd12, 14'd9999, 5'd1, 4'd1, 14'd1, 1'b1}, TYPED, '{22'd1, 1'b0}},
        '{'{5'd1, 4'd0, 14'd2000, 5'd1, 4'd1, 14'd2001, 1'b1}, TYPED, BAD_RES},
        '{'{5'd1, 4'd1, 14'd2000, 5'd1, 4'd13, 14'd2001, 1'b0}, TYPED, BAD_RES},
        '{'{5'd31, 4'd15, 14'd16383, 5'd1, 4'd1, 14'd16383, 1'b1}, TYPED, BAD_RES},
        '{'{5'd1, 4'd1, 14'd1, 5'd0, 4'd6, 14'd5, 1'b1}, TYPED, BAD_RES},
        '{'{5'd29, 4'd2, 14'd1900, 5'd1, 4'd3, 14'd1900, 1'b0}, TYPED, BAD_RES},
        '{'{5'd29, 4'd2, 14'd2000, 5'd1, 4'd3, 14'd2000, 1'b0}, BY_MODEL, NO_RES},
        '{'{5'd29, 4'd2, 14'd2024, 5'd29, 4'd2, 14'd2028, 1'b1}, BY_MODEL, NO_RES},
        '{'{5'd31, 4'd4, 14'd2010, 5'd1, 4'd5, 14'd2010, 1'b0}, TYPED, BAD_RES},
        '{'{5'd28, 4'd2, 14'd1900, 5'd1, 4'd3, 14'd1900, 1'b0}, BY_MODEL, NO_RES},
        '{'{5'd29, 4'd2, 14'd0, 5'd1, 4'd3, 14'd0, 1'b0}, BY_MODEL, NO_RES},
        '{'{5'd31, 4'd1, 14'd16383, 5'd1, 4'd2, 14'd16383, 1'b1}, BY_MODEL, NO_RES},
        '{'{5'd1, 4'd1, 14'd2000, 5'd1, 4'd1, 14'd2001, 1'b0}, BY_MODEL, NO_RES},
        '{'{5'd1, 4'd1, 14'd2100, 5'd1, 4'd1, 14'd2101, 1'b0}, BY_MODEL, NO_RES},
        '{'{5'd30, 4'd6, 14'd1999, 5'd30, 4'd6, 14'd1999, 1'b1}, TYPED, '{22'd1, 1'b0}},
        '{'{5'd15, 4'd8, 14'd4000, 5'd14, 4'd8, 14'd4000, 1'b0}, TYPED, NO_RES},
        '{'{5'd31, 4'd11, 14'd300, 5'd1, 4'd1, 14'd100, 1'b1}, TYPED, BAD_RES},
        '{'{5'd1, 4'd3, 14'd1, 5'd31, 4'd12, 14'd4, 1'b0}, BY_MODEL, NO_RES}
    };

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    // start_day, start_month, start_year, end_day, end_month, end_year, zero fill
    logic [47:0] s_tdata;
    // include_end
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    // day_count, zero fill
    logic [23:0] m_tdata;
    // bad_date
    logic [0:0]  m_tuser;

    day_result_t pending_results[$];
    int          mismatch_count = 0;
    int          results_taken  = 0;
    int          bad_seen       = 0;
    int          saturated_seen = 0;
    int          idle_cycles    = 0;

    gregorian_days_between_dates_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Clock generation.
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Calendar helpers for the predictor.
    function automatic bit is_leap(input int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int month_days(input int m, input int y);
        if (m < 1 || m > 12)
            return 0;
        if (m == 2)
            return is_leap(y) ? 29 : 28;
        return LEN_TABLE[m-1];
    endfunction

    // Day index from a fixed origin; year 0 counts as a leap year.
    function automatic int day_index(input int d, input int m, input int y);
        int leaps;
        int p;
        leaps = 0;
        if (y > 0)
        begin
            p     = y - 1;
            leaps = p / 4 - p / 100 + p / 400 + 1;
        end
        return 365 * y + leaps + CUM_TABLE[m-1] + ((m > 2 && is_leap(y)) ? 1 : 0) + d;
    endfunction

    // Predicts the result transaction for one date pair.
    function automatic day_result_t days_between(input date_query_t q);
        day_result_t res;
        int          a;
        int          b;
        int          count;
        res = NO_RES;
        if (int'(q.sd) < 1 || int'(q.sd) > month_days(int'(q.sm), int'(q.sy)) ||
            int'(q.ed) < 1 || int'(q.ed) > month_days(int'(q.em), int'(q.ey)))
        begin
            res.bad = 1'b1;
        end
        else
        begin
            a     = day_index(int'(q.sd), int'(q.sm), int'(q.sy));
            b     = day_index(int'(q.ed), int'(q.em), int'(q.ey));
            count = (a < b) ? b - a : 0;
            count = count + int'(q.inc);
            if (count > int'(gdbd_pkg::COUNT_MAX))
                count = int'(gdbd_pkg::COUNT_MAX);
            res.count = count[gdbd_pkg::COUNT_W-1:0];
        end
        return res;
    endfunction

    // Mostly well-formed date pairs, with some broken dates and raw noise.
    function automatic date_query_t random_query();
        date_query_t q;
        date_query_t swapped;
        int          kind;
        int          span;
        int          sy;
        int          ey;
        kind  = $urandom_range(0, 99);
        q.inc = 1'($urandom_range(0, 1));
        if (kind < 10)
        begin
            q.sd = 5'($urandom);
            q.sm = 4'($urandom);
            q.sy = 14'($urandom);
            q.ed = 5'($urandom);
            q.em = 4'($urandom);
            q.ey = 14'($urandom);
            return q;
        end
        sy = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 16383) : $urandom_range(1, 9999);
        case ($urandom_range(0, 3))
            0:       span = 0;
            1:       span = 3;
            2:       span = 60;
            default: span = 9999;
        endcase
        ey = sy + $urandom_range(0, span);
        if (ey > 16383)
            ey = 16383;
        q.sy = 14'(sy);
        q.ey = 14'(ey);
        q.sm = 4'($urandom_range(1, 12));
        q.sd = 5'($urandom_range(1, month_days(int'(q.sm), sy)));
        q.em = 4'($urandom_range(1, 12));
        q.ed = 5'($urandom_range(1, month_days(int'(q.em), ey)));
        // Some pairs come in the wrong order.
        if ($urandom_range(0, 6) == 0)
        begin
            swapped = q;
            swapped.sd = q.ed;
            swapped.sm = q.em;
            swapped.sy = q.ey;
            swapped.ed = q.sd;
            swapped.em = q.sm;
            swapped.ey = q.sy;
            q = swapped;
        end
        // Break one field of an otherwise valid pair.
        if (kind < 20)
        begin
            case ($urandom_range(0, 5))
                0:
                begin
                    q.sd = 5'd0;
                end
                1:
                begin
                    q.sm = gdbd_pkg::MONTH_FEB;
                    q.sd = 5'($urandom_range(30, 31));
                end
                2:
                begin
                    q.sm = ($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(13, 15));
                end
                3:
                begin
                    q.ed = 5'd0;
                end
                4:
                begin
                    q.em = ($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(13, 15));
                end
                default:
                begin
                    q.em = 4'd11;
                    q.ed = 5'd31;
                end
            endcase
        end
        return q;
    endfunction

    // Offers one transaction after a gap and books its expected result on acceptance.
    task automatic offer_query(input date_query_t q, input int gap, input day_result_t want);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, q.ey, q.em, q.ed, q.sy, q.sm, q.sd};
        s_tuser  <= q.inc;
        do @(posedge clk); while (!s_tready);
        pending_results.push_back(want);
        @(negedge clk);
    endtask

    // Stops offering and waits until every booked result has come back.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic report_mismatch(input string what, input int want, input int got);
        mismatch_count++;
        if (mismatch_count <= SHOWN_ERRORS)
            $display("Mismatch on result %0d, %s: expected %0d, got %0d",
                     results_taken, what, want, got);
    endtask

    // Sender: reset, directed table, then random transactions.
    initial
    begin
        date_query_t q;
        day_result_t want;
        int          gap;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            q    = DIRECTED[i].q;
            want = (DIRECTED[i].kind == TYPED) ? DIRECTED[i].res : days_between(q);
            offer_query(q, $urandom_range(0, 4), want);
        end
        wait_for_results();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            // A pause partway through the random items lets the core drain completely.
            if (i == RANDOM_ITEMS / 2 + 10)
                wait_for_results();
            gap = ((i % 32) >= 24) ? 0 : $urandom_range(0, 4);
            q   = random_query();
            offer_query(q, gap, days_between(q));
        end
        wait_for_results();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Ran %0d directed and %0d random date pairs; %0d results checked.",
                 DIRECTED_ROWS, RANDOM_ITEMS, results_taken);
        $display("Bad dates flagged: %0d, saturated counts: %0d, one long output stall.",
                 bad_seen, saturated_seen);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Receiver: random stalls, bursts without stalls, and one long hold-off.
    initial
    begin
        day_result_t want;
        int          stall;
        m_tready = 1'b0;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            if (results_taken == HOLD_AT_RESULT)
                stall = HOLD_CYCLES;
            else if ((results_taken % 32) >= 24)
                stall = 0;
            else
                stall = $urandom_range(0, 4);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected transaction", 0, 1);
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[gdbd_pkg::COUNT_W-1:0] !== want.count)
                    report_mismatch("day_count", int'(want.count),
                                    int'(m_tdata[gdbd_pkg::COUNT_W-1:0]));
                if (m_tuser[0] !== want.bad)
                    report_mismatch("bad_date", int'(want.bad), int'(m_tuser[0]));
                if (want.bad)
                    bad_seen++;
                if (want.count == gdbd_pkg::COUNT_MAX)
                    saturated_seen++;
            end
            results_taken++;
            @(negedge clk);
        end
    end

    // Watchdog on cycles without any accepted transaction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Timeout after %0d cycles without a transaction.", idle_cycles);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

endmodule

### filelist.f
sv/gdbd_pkg.sv
sv/gdbd_ctrl.sv
sv/gdbd_dp.sv
sv/gregorian_days_between_dates_core.sv
verif/tb_top.sv
